// ----- rtl/core/lfc_pkg.sv -----
package lfc_pkg;

  // fixed sizes of the datapath
  localparam int MAX_TAPS       = 7;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_BITS      = 16;
  localparam int NUM_COEF       = 7;
  localparam int HALF_MAX       = (MAX_TAPS - 1) / 2;
  localparam int HALF_BITS      = 2;
  localparam int CNT_BITS       = 3;
  localparam int COEF_IDX_BITS  = $clog2(NUM_COEF);
  localparam int CFG_IDX_BITS   = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int QUEUE_DEPTH    = 4;

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FIRST = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_LAST  = CFG_IDX_BITS'(NUM_COEF);

  // unity gain in Q1.14
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] window_t;

  typedef struct packed {
    sample_t sample;
    logic    line_end;
  } in_item_t;

  typedef struct packed {
    sample_t filtered;
    logic    saturated;
    logic    line_last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] value;
  } cfg_item_t;

  // one pending output: window snapshot and end-of-line mark
  typedef struct packed {
    logic    last;
    window_t win;
  } job_t;

  // clamp half width to what the window can hold
  function automatic logic [HALF_BITS-1:0] eff_half(input logic [HALF_BITS-1:0] h);
    logic [HALF_BITS-1:0] r;
    r = (int'(h) > HALF_MAX) ? HALF_BITS'(HALF_MAX) : h;
    return r;
  endfunction

endpackage

// ----- rtl/core/lfc_chan_if.sv -----
interface lfc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/lfc_queue.sv -----
module lfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lfc_pkg::job_t push_data,
  output logic          room,
  input  logic          pop,
  output logic          avail,
  output lfc_pkg::job_t pop_data
);
  import lfc_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wptr;
  logic [PTR_BITS-1:0] rptr;
  logic [CNT_W-1:0]    count;

  assign room     = (count != CNT_W'(QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = entries[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_BITS'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end
endmodule

// ----- rtl/core/lfc_front.sv -----
module lfc_front (
  input  logic                           clk,
  input  logic                           rst,
  lfc_chan_if.sink                       samples,
  input  logic [lfc_pkg::HALF_BITS-1:0]  half,
  input  logic                           room,
  output logic                           push,
  output lfc_pkg::job_t                  push_data
);
  import lfc_pkg::*;

  window_t              win;
  window_t              win_shift;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  cnt_inc;
  logic [HALF_BITS-1:0] zeros;
  logic [HALF_BITS-1:0] zeros_inc;
  logic                 flushing;
  logic                 take;
  logic                 flush_step;
  logic                 emit;
  logic [SAMPLE_BITS-1:0] shift_val;

  // stall requests during the end-of-line flush or while the queue is full
  assign samples.ready = !flushing && room;
  assign take          = samples.valid && samples.ready;
  assign flush_step    = flushing && room;

  // window advance, saturating sample count
  always_comb begin
    shift_val = flushing ? '0 : samples.data.sample;
    for (int i = 0; i < MAX_TAPS - 1; i++) begin
      win_shift[i] = win[i+1];
    end
    win_shift[MAX_TAPS-1] = shift_val;
    cnt_inc   = (cnt == {CNT_BITS{1'b1}}) ? cnt : cnt + CNT_BITS'(1);
    zeros_inc = zeros + HALF_BITS'(1);
  end

  // an output is owed once more than half-width samples are in
  assign emit = cnt_inc > {{(CNT_BITS-HALF_BITS){1'b0}}, half};
  assign push = (take || flush_step) && emit;

  assign push_data.win  = win_shift;
  assign push_data.last = flushing ? (zeros_inc == half)
                                   : (samples.data.line_end && half == '0);

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      cnt      <= '0;
      zeros    <= '0;
      flushing <= 1'b0;
    end else if (take) begin
      if (samples.data.line_end && half == '0) begin
        win <= '0;
        cnt <= '0;
      end else begin
        win <= win_shift;
        cnt <= cnt_inc;
        if (samples.data.line_end) begin
          flushing <= 1'b1;
          zeros    <= '0;
        end
      end
    end else if (flush_step) begin
      if (zeros_inc == half) begin
        flushing <= 1'b0;
        win      <= '0;
        cnt      <= '0;
      end else begin
        win   <= win_shift;
        cnt   <= cnt_inc;
        zeros <= zeros_inc;
      end
    end
  end
endmodule

// ----- rtl/core/lfc_back.sv -----
module lfc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          avail,
  input  lfc_pkg::job_t                 job,
  output logic                          pop,
  input  logic [lfc_pkg::HALF_BITS-1:0] half,
  input  lfc_pkg::coef_t                coefs [lfc_pkg::NUM_COEF],
  lfc_chan_if.source                    results
);
  import lfc_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_BITS  = PROD_BITS + $clog2(MAX_TAPS);
  localparam int Q_BITS    = SUM_BITS - COEF_FRAC_BITS;
  localparam logic signed [SUM_BITS-1:0] RND   = SUM_BITS'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [Q_BITS-1:0]   Q_MAX = Q_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_BITS-1:0]   Q_MIN = -Q_MAX - Q_BITS'(1);

  logic                        en;
  coef_t                       coef_sel [MAX_TAPS];
  logic signed [PROD_BITS-1:0] prod [MAX_TAPS];
  logic                        v1;
  logic                        last1;
  logic signed [SUM_BITS-1:0]  sum_comb;
  logic signed [SUM_BITS-1:0]  sum;
  logic                        v2;
  logic                        last2;
  logic signed [SUM_BITS-1:0]  rounded;
  logic signed [Q_BITS-1:0]    q;
  logic                        ov;
  out_item_t                   od;
  out_item_t                   od_comb;

  // whole pipe moves unless the output register is held
  assign en            = !ov || results.ready;
  assign pop           = en && avail;
  assign results.valid = ov;
  assign results.data  = od;

  // tap j weights window slot MAX_TAPS-1-2h+j
  always_comb begin
    int j;
    j = 0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      j = i + 2 * int'(half) - (MAX_TAPS - 1);
      coef_sel[i] = (j >= 0 && j < NUM_COEF) ? coefs[COEF_IDX_BITS'(j)] : '0;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        prod[i] <= $signed(job.win[i]) * coef_sel[i];
      end
      last1 <= job.last;
    end
  end

  // stage 2: sum of products
  always_comb begin
    sum_comb = '0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      sum_comb = sum_comb + SUM_BITS'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum   <= sum_comb;
      last2 <= last1;
    end
  end

  // stage 3: round half up, floor, clip
  always_comb begin
    rounded = sum + RND;
    q       = $signed(rounded[SUM_BITS-1:COEF_FRAC_BITS]);
    od_comb.line_last = last2;
    if (q > Q_MAX) begin
      od_comb.filtered  = Q_MAX[SAMPLE_BITS-1:0];
      od_comb.saturated = 1'b1;
    end else if (q < Q_MIN) begin
      od_comb.filtered  = Q_MIN[SAMPLE_BITS-1:0];
      od_comb.saturated = 1'b1;
    end else begin
      od_comb.filtered  = q[SAMPLE_BITS-1:0];
      od_comb.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      od <= od_comb;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      v1 <= avail;
      v2 <= v1;
      ov <= v2;
    end
  end
endmodule

// ----- rtl/core/line_fir_convolver_zero_pad.sv -----
// path: a request that completes its window is queued, then passes the product, sum
// and output registers; throughput: one request per cycle while the queue has room;
// a line end with half width h holds off requests while zeros shift into the window
// back end: three-stage multiply, sum, clip pipe; one window a cycle unless results stall
// reset: synchronous, active high; clears window, counts, queue and pipe valids,
// and sets half width 0, coef_0 to 1.0 and the other taps to 0
module line_fir_convolver_zero_pad (
  input  logic       clk,
  input  logic       rst,
  lfc_chan_if.sink   samples,
  lfc_chan_if.source results,
  lfc_chan_if.sink   cfg
);
  import lfc_pkg::*;

  logic [HALF_BITS-1:0] half_width;
  logic [HALF_BITS-1:0] half;
  coef_t                coefs [NUM_COEF];
  logic                 cfg_take;
  logic                 push;
  job_t                 push_data;
  logic                 room;
  logic                 pop;
  logic                 avail;
  job_t                 pop_data;

  // register writes always taken
  assign cfg.ready = 1'b1;
  assign cfg_take  = cfg.valid;
  assign half      = eff_half(half_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coefs[i] <= (i == 0) ? COEF_ONE : '0;
      end
    end else if (cfg_take) begin
      if (cfg.data.index == REG_HALF_WIDTH) begin
        half_width <= cfg.data.value[HALF_BITS-1:0];
      end else if (cfg.data.index >= REG_COEF_FIRST && cfg.data.index <= REG_COEF_LAST) begin
        coefs[COEF_IDX_BITS'(cfg.data.index - REG_COEF_FIRST)] <=
          $signed(cfg.data.value[COEF_BITS-1:0]);
      end
    end
  end

  lfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .half      (half),
    .room      (room),
    .push      (push),
    .push_data (push_data)
  );

  lfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .room      (room),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  lfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (avail),
    .job     (pop_data),
    .pop     (pop),
    .half    (half),
    .coefs   (coefs),
    .results (results)
  );
endmodule
